@@ rtl/bss_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_pkg: shared definitions for the bilinear sprite scaler
// Store geometry, fixed-point widths, register and opcode codes, and the
// RGB565 linear blend used by both interpolation stages.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int SRC_MAX_WIDTH  = 256;
    localparam int SRC_MAX_HEIGHT = 256;
    localparam int DEST_WORDS     = 1048576;
    localparam int FRAC_BITS      = 16;

    localparam int COL_W      = $clog2(SRC_MAX_WIDTH);
    localparam int ROW_W      = $clog2(SRC_MAX_HEIGHT);
    localparam int BANK_AW    = (COL_W - 1) + (ROW_W - 1);
    localparam int BANK_DEPTH = (SRC_MAX_WIDTH * SRC_MAX_HEIGHT) / 4;

    localparam int SW_W     = 9;
    localparam int TW_W     = 11;
    localparam int COORD_W  = 10;
    localparam int POS_W    = 12;
    localparam int PITCH_W  = 13;
    localparam int PIX_W    = 16;
    localparam int ADDR_W   = 20;
    localparam int RATIO_W  = SW_W + FRAC_BITS;
    localparam int PX_W     = COORD_W + RATIO_W;
    localparam int IDX_W    = PX_W - FRAC_BITS;
    localparam int DCNT_W   = $clog2(RATIO_W);
    localparam int OFF_W    = 14;
    localparam int PROD_W   = 2 * OFF_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int ACC_W    = FRAC_BITS + 8;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_TRG_WIDTH  = 3'd2,
        REG_TRG_HEIGHT = 3'd3,
        REG_KEY_ENABLE = 3'd4,
        REG_KEY_COLOR  = 3'd5,
        REG_DEST_PITCH = 3'd6
    } cfg_reg_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_REQUEST = 1'b1
    } opcode_t;

    function automatic logic [5:0] blend_chan(input logic [5:0] a, input logic [5:0] b,
                                              input logic [FRAC_BITS-1:0] f);
        logic [ACC_W-1:0] wa_e;
        logic [ACC_W-1:0] f_e;
        logic [ACC_W-1:0] acc;
        wa_e = ACC_W'({1'b1, {FRAC_BITS{1'b0}}}) - ACC_W'(f);
        f_e  = ACC_W'(f);
        acc  = wa_e * ACC_W'(a) + f_e * ACC_W'(b);
        return acc[FRAC_BITS +: 6];
    endfunction

    function automatic logic [15:0] lerp565(input logic [15:0] a, input logic [15:0] b,
                                            input logic [FRAC_BITS-1:0] f);
        logic [5:0] r;
        logic [5:0] g;
        logic [5:0] bl;
        r  = blend_chan({1'b0, a[15:11]}, {1'b0, b[15:11]}, f);
        g  = blend_chan(a[10:5], b[10:5], f);
        bl = blend_chan({1'b0, a[4:0]}, {1'b0, b[4:0]}, f);
        return {r[4:0], g, bl[4:0]};
    endfunction

endpackage
`default_nettype wire

@@ rtl/bss_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bss_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module bss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/bilinear_sprite_scaler_color_key.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_sprite_scaler_color_key: RGB565 sprite scaler with color key
// Loads a sprite into four parity-banked RAMs and produces one bilinearly
// interpolated, centered destination pixel per request transaction.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock while the output is not held
// off and no ratio division runs; load transactions produce no result. The
// four neighbors of a source position are read in the same cycle from four
// RAM banks split by row and column parity, so the store never limits the
// rate. The scale ratios are divided out one quotient bit per clock: after a
// write to any of the four size registers the input is held off while the
// restoring divider runs on both axes. The source store has no clearing
// pass; pixels that were never loaded read as unknown.
module bilinear_sprite_scaler_color_key (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    input  wire logic [15:0] s_pixel,
    input  wire logic [9:0]  s_coord_x,
    input  wire logic [9:0]  s_coord_y,
    input  wire logic [11:0] s_pos_x,
    input  wire logic [11:0] s_pos_y,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [19:0]      m_dest_address,
    output logic [15:0]      m_color,
    output logic             m_write_enable
);

    localparam int FB = bss_pkg::FRAC_BITS;

    // Configuration registers
    logic [bss_pkg::SW_W-1:0]    src_width_reg, src_height_reg;
    logic [bss_pkg::TW_W-1:0]    trg_width_reg, trg_height_reg;
    logic                        key_enable_reg;
    logic [bss_pkg::PIX_W-1:0]   key_color_reg;
    logic [bss_pkg::PITCH_W-1:0] dest_pitch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= bss_pkg::SW_W'(2);
            src_height_reg <= bss_pkg::SW_W'(2);
            trg_width_reg  <= bss_pkg::TW_W'(1);
            trg_height_reg <= bss_pkg::TW_W'(1);
            key_enable_reg <= 1'b0;
            key_color_reg  <= '0;
            dest_pitch_reg <= bss_pkg::PITCH_W'(640);
        end else if (cfg_we) begin
            unique case (cfg_index)
                bss_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[bss_pkg::SW_W-1:0];
                bss_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[bss_pkg::SW_W-1:0];
                bss_pkg::REG_TRG_WIDTH:  trg_width_reg  <= cfg_data[bss_pkg::TW_W-1:0];
                bss_pkg::REG_TRG_HEIGHT: trg_height_reg <= cfg_data[bss_pkg::TW_W-1:0];
                bss_pkg::REG_KEY_ENABLE: key_enable_reg <= cfg_data[0];
                bss_pkg::REG_KEY_COLOR:  key_color_reg  <= cfg_data;
                bss_pkg::REG_DEST_PITCH: dest_pitch_reg <= cfg_data[bss_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Ratio divider: both axes in parallel, one quotient bit per clock.
    logic                        div_start_reg, div_busy_reg;
    logic [bss_pkg::DCNT_W-1:0]  div_cnt_reg;
    logic [bss_pkg::RATIO_W-1:0] qx_reg, qy_reg, ratio_x_reg, ratio_y_reg;
    logic [bss_pkg::TW_W-1:0]    remx_reg, remy_reg;
    logic [bss_pkg::TW_W-1:0]    divx, divy;
    logic [bss_pkg::SW_W-1:0]    sxm1, sym1;
    logic [bss_pkg::TW_W:0]      shx, shy, trx, try_;
    logic [bss_pkg::RATIO_W-1:0] qx_next, qy_next;
    logic [bss_pkg::TW_W-1:0]    remx_next, remy_next;
    logic                        size_write;

    assign size_write = cfg_we && (cfg_index == bss_pkg::REG_SRC_WIDTH
                        || cfg_index == bss_pkg::REG_SRC_HEIGHT
                        || cfg_index == bss_pkg::REG_TRG_WIDTH
                        || cfg_index == bss_pkg::REG_TRG_HEIGHT);

    always_comb begin
        divx = (trg_width_reg == '0) ? bss_pkg::TW_W'(1) : trg_width_reg;
        divy = (trg_height_reg == '0) ? bss_pkg::TW_W'(1) : trg_height_reg;
        sxm1 = (src_width_reg == '0) ? '0 : src_width_reg - bss_pkg::SW_W'(1);
        sym1 = (src_height_reg == '0) ? '0 : src_height_reg - bss_pkg::SW_W'(1);
        shx  = {remx_reg, qx_reg[bss_pkg::RATIO_W-1]};
        shy  = {remy_reg, qy_reg[bss_pkg::RATIO_W-1]};
        trx  = shx - {1'b0, divx};
        try_ = shy - {1'b0, divy};
        remx_next = (shx >= {1'b0, divx}) ? trx[bss_pkg::TW_W-1:0] : shx[bss_pkg::TW_W-1:0];
        remy_next = (shy >= {1'b0, divy}) ? try_[bss_pkg::TW_W-1:0] : shy[bss_pkg::TW_W-1:0];
        qx_next = {qx_reg[bss_pkg::RATIO_W-2:0], shx >= {1'b0, divx}};
        qy_next = {qy_reg[bss_pkg::RATIO_W-2:0], shy >= {1'b0, divy}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_start_reg <= 1'b0;
            div_busy_reg  <= 1'b0;
            div_cnt_reg   <= '0;
            ratio_x_reg   <= bss_pkg::RATIO_W'(1) << FB;
            ratio_y_reg   <= bss_pkg::RATIO_W'(1) << FB;
        end else begin
            div_start_reg <= size_write;
            if (div_start_reg) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + bss_pkg::DCNT_W'(1);
                if (div_cnt_reg == bss_pkg::DCNT_W'(bss_pkg::RATIO_W - 1)) begin
                    div_busy_reg <= 1'b0;
                    ratio_x_reg  <= qx_next;
                    ratio_y_reg  <= qy_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_start_reg) begin
            qx_reg   <= {sxm1, {FB{1'b0}}};
            qy_reg   <= {sym1, {FB{1'b0}}};
            remx_reg <= '0;
            remy_reg <= '0;
        end else begin
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            remx_reg <= remx_next;
            remy_reg <= remy_next;
        end
    end

    // Pipeline stage enables; each stage moves when its successor has room.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic out_free, en1, en2, en3, en4;

    assign out_free = !m_valid || m_ready;
    assign en4      = !v4_reg || out_free;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_ready  = en1 && !div_busy_reg && !div_start_reg;

    // Stage 1: accepted transaction
    logic                      s1_op_reg;
    logic [15:0]               s1_pix_reg;
    logic [9:0]                s1_cx_reg, s1_cy_reg;
    logic [11:0]               s1_px_reg, s1_py_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid && s_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_op_reg  <= s_opcode;
            s1_pix_reg <= s_pixel;
            s1_cx_reg  <= s_coord_x;
            s1_cy_reg  <= s_coord_y;
            s1_px_reg  <= s_pos_x;
            s1_py_reg  <= s_pos_y;
        end
    end

    // Stage 1 logic: source position products, centering offsets and the target range check.
    logic [bss_pkg::PX_W-1:0]         px1, py1;
    logic signed [11:0]               dx, dy, hx, hy;
    logic signed [bss_pkg::OFF_W-1:0] ax1, ay1;
    logic                             inside1;

    always_comb begin
        px1 = bss_pkg::PX_W'(s1_cx_reg) * bss_pkg::PX_W'(ratio_x_reg);
        py1 = bss_pkg::PX_W'(s1_cy_reg) * bss_pkg::PX_W'(ratio_y_reg);
        dx = $signed({1'b0, trg_width_reg}) - $signed({3'b0, src_width_reg});
        dy = $signed({1'b0, trg_height_reg}) - $signed({3'b0, src_height_reg});
        // Halve with truncation toward zero.
        hx = dx[11] ? ((dx + 12'sd1) >>> 1) : (dx >>> 1);
        hy = dy[11] ? ((dy + 12'sd1) >>> 1) : (dy >>> 1);
        ax1 = $signed({4'b0, s1_cx_reg}) + bss_pkg::OFF_W'($signed(s1_px_reg))
              - bss_pkg::OFF_W'(hx);
        ay1 = $signed({4'b0, s1_cy_reg}) + bss_pkg::OFF_W'($signed(s1_py_reg))
              - bss_pkg::OFF_W'(hy);
        inside1 = ({1'b0, s1_cx_reg} < trg_width_reg) && ({1'b0, s1_cy_reg} < trg_height_reg);
    end

    // Stage 2
    logic                             s2_op_reg, s2_inside_reg;
    logic [15:0]                      s2_pix_reg;
    logic [9:0]                       s2_cx_reg, s2_cy_reg;
    logic [bss_pkg::PX_W-1:0]         s2_px_reg, s2_py_reg;
    logic signed [bss_pkg::OFF_W-1:0] s2_ax_reg, s2_ay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_op_reg     <= s1_op_reg;
            s2_inside_reg <= inside1;
            s2_pix_reg    <= s1_pix_reg;
            s2_cx_reg     <= s1_cx_reg;
            s2_cy_reg     <= s1_cy_reg;
            s2_px_reg     <= px1;
            s2_py_reg     <= py1;
            s2_ax_reg     <= ax1;
            s2_ay_reg     <= ay1;
        end
    end

    // Stage 2 logic: neighbor indices with saturation, bank reads and loads.
    logic [bss_pkg::IDX_W-1:0]   ix2, iy2;
    logic [bss_pkg::COL_W-1:0]   c0, c1;
    logic [bss_pkg::ROW_W-1:0]   r0, r1;
    logic [bss_pkg::COL_W-1:0]   cpar [2];
    logic [bss_pkg::ROW_W-1:0]   rpar [2];
    logic [bss_pkg::BANK_AW-1:0] raddr [4];
    logic [bss_pkg::BANK_AW-1:0] waddr;
    logic [15:0]                 rdata [4];
    logic                        load_ok, is_load2;
    logic signed [bss_pkg::PROD_W-1:0] yprod2;

    always_comb begin
        ix2 = s2_px_reg[bss_pkg::PX_W-1:FB];
        iy2 = s2_py_reg[bss_pkg::PX_W-1:FB];
        c0 = (ix2 > bss_pkg::IDX_W'(bss_pkg::SRC_MAX_WIDTH - 1))
             ? bss_pkg::COL_W'(bss_pkg::SRC_MAX_WIDTH - 1) : ix2[bss_pkg::COL_W-1:0];
        c1 = (ix2 >= bss_pkg::IDX_W'(bss_pkg::SRC_MAX_WIDTH - 1))
             ? bss_pkg::COL_W'(bss_pkg::SRC_MAX_WIDTH - 1)
             : ix2[bss_pkg::COL_W-1:0] + bss_pkg::COL_W'(1);
        r0 = (iy2 > bss_pkg::IDX_W'(bss_pkg::SRC_MAX_HEIGHT - 1))
             ? bss_pkg::ROW_W'(bss_pkg::SRC_MAX_HEIGHT - 1) : iy2[bss_pkg::ROW_W-1:0];
        r1 = (iy2 >= bss_pkg::IDX_W'(bss_pkg::SRC_MAX_HEIGHT - 1))
             ? bss_pkg::ROW_W'(bss_pkg::SRC_MAX_HEIGHT - 1)
             : iy2[bss_pkg::ROW_W-1:0] + bss_pkg::ROW_W'(1);
        // Column of each parity among the two neighbors; same for rows.
        cpar[0] = c0[0] ? c1 : c0;
        cpar[1] = c0[0] ? c0 : c1;
        rpar[0] = r0[0] ? r1 : r0;
        rpar[1] = r0[0] ? r0 : r1;
        for (int b = 0; b < 4; b++) begin
            raddr[b] = {rpar[b / 2][bss_pkg::ROW_W-1:1], cpar[b % 2][bss_pkg::COL_W-1:1]};
        end
        is_load2 = v2_reg && (s2_op_reg == bss_pkg::OP_LOAD);
        load_ok  = (s2_cx_reg < 10'(bss_pkg::SRC_MAX_WIDTH))
                   && (s2_cy_reg < 10'(bss_pkg::SRC_MAX_HEIGHT));
        waddr = {s2_cy_reg[bss_pkg::ROW_W-1:1], s2_cx_reg[bss_pkg::COL_W-1:1]};
        yprod2 = bss_pkg::PROD_W'(s2_ay_reg)
                 * bss_pkg::PROD_W'($signed({1'b0, dest_pitch_reg}));
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        bss_ram #(
            .WIDTH(bss_pkg::PIX_W),
            .DEPTH(bss_pkg::BANK_DEPTH)
        ) u_bank (
            .aclk (aclk),
            .we   (is_load2 && en3 && load_ok
                   && s2_cy_reg[0] == 1'(g / 2) && s2_cx_reg[0] == 1'(g % 2)),
            .waddr(waddr),
            .wdata(s2_pix_reg),
            .re   (en3),
            .raddr(raddr[g]),
            .rdata(rdata[g])
        );
    end

    // Stage 3: bank data plus the neighbor parities
    logic                              s3_c0p_reg, s3_c1p_reg, s3_r0p_reg, s3_r1p_reg;
    logic [FB-1:0]                     s3_fx_reg, s3_fy_reg;
    logic signed [bss_pkg::OFF_W-1:0]  s3_ax_reg;
    logic signed [bss_pkg::PROD_W-1:0] s3_yprod_reg;
    logic                              s3_inside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg && (s2_op_reg == bss_pkg::OP_REQUEST);
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_c0p_reg    <= c0[0];
            s3_c1p_reg    <= c1[0];
            s3_r0p_reg    <= r0[0];
            s3_r1p_reg    <= r1[0];
            s3_fx_reg     <= s2_px_reg[FB-1:0];
            s3_fy_reg     <= s2_py_reg[FB-1:0];
            s3_ax_reg     <= s2_ax_reg;
            s3_yprod_reg  <= yprod2;
            s3_inside_reg <= s2_inside_reg;
        end
    end

    // Stage 3 logic: vertical blends of both columns, address range check.
    logic [15:0]                      p00, p01, p10, p11, cb1, cb2;
    logic signed [bss_pkg::SUM_W-1:0] addr3;
    logic                             addr_ok3;

    always_comb begin
        p00 = rdata[{s3_r0p_reg, s3_c0p_reg}];
        p01 = rdata[{s3_r1p_reg, s3_c0p_reg}];
        p10 = rdata[{s3_r0p_reg, s3_c1p_reg}];
        p11 = rdata[{s3_r1p_reg, s3_c1p_reg}];
        if (key_enable_reg && p00 == key_color_reg) begin
            cb1 = p01;
        end else if (key_enable_reg && p01 == key_color_reg) begin
            cb1 = p00;
        end else begin
            cb1 = bss_pkg::lerp565(p00, p01, s3_fy_reg);
        end
        if (key_enable_reg && p10 == key_color_reg) begin
            cb2 = p11;
        end else if (key_enable_reg && p11 == key_color_reg) begin
            cb2 = p10;
        end else begin
            cb2 = bss_pkg::lerp565(p10, p11, s3_fy_reg);
        end
        addr3 = bss_pkg::SUM_W'(s3_yprod_reg) + bss_pkg::SUM_W'(s3_ax_reg);
        addr_ok3 = !addr3[bss_pkg::SUM_W-1]
                   && (addr3 < bss_pkg::SUM_W'(bss_pkg::DEST_WORDS));
    end

    // Stage 4
    logic [15:0]               s4_c1_reg, s4_c2_reg;
    logic [FB-1:0]             s4_fx_reg;
    logic [bss_pkg::ADDR_W-1:0] s4_addr_reg;
    logic                      s4_we_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_c1_reg   <= cb1;
            s4_c2_reg   <= cb2;
            s4_fx_reg   <= s3_fx_reg;
            s4_addr_reg <= addr_ok3 ? addr3[bss_pkg::ADDR_W-1:0] : '0;
            s4_we_reg   <= addr_ok3 && s3_inside_reg;
        end
    end

    // Stage 4 logic: horizontal blend and transparency.
    logic        k1, k2;
    logic [15:0] color4;
    logic        we4;

    always_comb begin
        k1 = key_enable_reg && (s4_c1_reg == key_color_reg);
        k2 = key_enable_reg && (s4_c2_reg == key_color_reg);
        we4 = s4_we_reg;
        priority if (k1 && k2) begin
            color4 = '0;
            we4    = 1'b0;
        end else if (k1) begin
            color4 = s4_c2_reg;
        end else if (k2) begin
            color4 = s4_c1_reg;
        end else begin
            color4 = bss_pkg::lerp565(s4_c1_reg, s4_c2_reg, s4_fx_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_dest_address <= s4_addr_reg;
            m_color        <= color4;
            m_write_enable <= we4;
        end
    end

    // Input is held off while the ratios are being recomputed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy_reg |-> !s_ready)
        else $error("input accepted during ratio division");

    // A division only starts after a write to a size register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> $past(cfg_we))
        else $error("ratio division started without a configuration write");

    // Load transactions never reach the blend stages.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && en3 && s2_op_reg == bss_pkg::OP_LOAD) |=> !v3_reg)
        else $error("load transaction entered the blend pipeline");

    // A transaction is only accepted when stage one can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted transaction was lost");

endmodule
`default_nettype wire

@@ bench/tb_bilinear_sprite_scaler_color_key.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilinear_sprite_scaler_color_key: self-checking bench for the sprite scaler
// Loads source pixels, issues scaled-pixel requests under many register
// settings and compares each returned address, color and write flag against
// an in-bench bilinear predictor, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_bilinear_sprite_scaler_color_key;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 800000;
    localparam int STORE_WORDS = bss_pkg::SRC_MAX_WIDTH * bss_pkg::SRC_MAX_HEIGHT;

    typedef struct packed {
        logic [19:0] address;
        logic [15:0] color;
        logic        wr;
    } scaled_px_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [15:0] s_pixel = '0;
    logic [9:0]  s_coord_x = '0;
    logic [9:0]  s_coord_y = '0;
    logic [11:0] s_pos_x = '0;
    logic [11:0] s_pos_y = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [19:0] m_dest_address;
    logic [15:0] m_color;
    logic        m_write_enable;

    bilinear_sprite_scaler_color_key dut (.*);

    // Mirror of the block: registers, sprite store and which words were loaded.
    logic [8:0]  src_w, src_h;
    logic [10:0] trg_w, trg_h;
    logic        key_on;
    logic [15:0] key_val;
    logic [12:0] pitch;
    logic [15:0] sprite_mem [STORE_WORDS];
    bit          loaded [STORE_WORDS];

    scaled_px_t pending_px[$];
    int  err_count = 0;
    int  cycles = 0;
    int  sent_count = 0;
    bit  idling_on = 1'b1;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_bilinear_sprite_scaler_color_key: done, errors");
            $finish;
        end
    end

    always @(posedge aclk)
        m_ready <= idling_on ? ($urandom_range(99) >= 20) : 1'b1;

    // ---------------- predictor ----------------
    function automatic longint scale_ratio(longint s, longint t);
        longint sm1 = (s > 0) ? s - 1 : 0;
        longint tt = (t > 0) ? t : 1;
        return (sm1 << bss_pkg::FRAC_BITS) / tt;
    endfunction

    function automatic int store_addr(longint col, longint row);
        if (col > bss_pkg::SRC_MAX_WIDTH - 1) col = bss_pkg::SRC_MAX_WIDTH - 1;
        if (row > bss_pkg::SRC_MAX_HEIGHT - 1) row = bss_pkg::SRC_MAX_HEIGHT - 1;
        return int'(row) * bss_pkg::SRC_MAX_WIDTH + int'(col);
    endfunction

    function automatic longint mix_chan(longint a, longint b, longint f);
        return (((longint'(1) << bss_pkg::FRAC_BITS) - f) * a + f * b)
               >> bss_pkg::FRAC_BITS;
    endfunction

    function automatic logic [15:0] mix_rgb(logic [15:0] a, logic [15:0] b, longint f);
        logic [4:0] r, bl;
        logic [5:0] g;
        r  = 5'(mix_chan(a[15:11], b[15:11], f));
        g  = 6'(mix_chan(a[10:5], b[10:5], f));
        bl = 5'(mix_chan(a[4:0], b[4:0], f));
        return {r, g, bl};
    endfunction

    // A keyed pixel gives way to its partner before blending.
    function automatic logic [15:0] keyed_mix(logic [15:0] a, logic [15:0] b, longint f);
        if (key_on && a == key_val) return b;
        if (key_on && b == key_val) return a;
        return mix_rgb(a, b, f);
    endfunction

    function automatic scaled_px_t predict_px(logic [9:0] cx, logic [9:0] cy,
                                              logic [11:0] px, logic [11:0] py);
        scaled_px_t res;
        longint sx, sy, ix, iy, fx, fy, offx, offy, addr;
        logic [15:0] c1, c2;
        sx = longint'(cx) * scale_ratio(src_w, trg_w);
        sy = longint'(cy) * scale_ratio(src_h, trg_h);
        ix = sx >> bss_pkg::FRAC_BITS;
        iy = sy >> bss_pkg::FRAC_BITS;
        fx = sx & ((longint'(1) << bss_pkg::FRAC_BITS) - 1);
        fy = sy & ((longint'(1) << bss_pkg::FRAC_BITS) - 1);
        c1 = keyed_mix(sprite_mem[store_addr(ix, iy)], sprite_mem[store_addr(ix, iy + 1)], fy);
        c2 = keyed_mix(sprite_mem[store_addr(ix + 1, iy)],
                       sprite_mem[store_addr(ix + 1, iy + 1)], fy);
        res.wr = 1'b1;
        res.color = '0;
        if (key_on && c1 == key_val && c2 == key_val) res.wr = 1'b0;
        else if (key_on && c1 == key_val) res.color = c2;
        else if (key_on && c2 == key_val) res.color = c1;
        else res.color = mix_rgb(c1, c2, fx);
        if (cx >= trg_w || cy >= trg_h) res.wr = 1'b0;
        offx = longint'($signed(px)) - (longint'(trg_w) - longint'(src_w)) / 2;
        offy = longint'($signed(py)) - (longint'(trg_h) - longint'(src_h)) / 2;
        addr = (longint'(cx) + offx) + (longint'(cy) + offy) * longint'(pitch);
        if (addr < 0 || addr >= bss_pkg::DEST_WORDS) begin
            res.wr = 1'b0;
            addr = 0;
        end
        res.address = 20'(addr);
        return res;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        scaled_px_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_px.size() == 0) begin
                $error("unexpected result: dest_address %h color %h write_enable %b",
                       m_dest_address, m_color, m_write_enable);
                err_count++;
            end else begin
                want = pending_px.pop_front();
                if (m_dest_address !== want.address) begin
                    $error("dest_address: expected %h, got %h", want.address, m_dest_address);
                    err_count++;
                end
                if (m_color !== want.color) begin
                    $error("color: expected %h, got %h", want.color, m_color);
                    err_count++;
                end
                if (m_write_enable !== want.wr) begin
                    $error("write_enable: expected %b, got %b", want.wr, m_write_enable);
                    err_count++;
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic send_item(bss_pkg::opcode_t op, logic [15:0] pix, logic [9:0] cx,
                             logic [9:0] cy, logic [11:0] px, logic [11:0] py);
        while (idling_on && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_pixel   <= pix;
        s_coord_x <= cx;
        s_coord_y <= cy;
        s_pos_x   <= px;
        s_pos_y   <= py;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        if (op == bss_pkg::OP_LOAD) begin
            if (cx < bss_pkg::SRC_MAX_WIDTH && cy < bss_pkg::SRC_MAX_HEIGHT) begin
                sprite_mem[int'(cy) * bss_pkg::SRC_MAX_WIDTH + int'(cx)] = pix;
                loaded[int'(cy) * bss_pkg::SRC_MAX_WIDTH + int'(cx)] = 1'b1;
            end
        end else begin
            pending_px = {pending_px, predict_px(cx, cy, px, py)};
        end
    endtask

    function automatic logic [15:0] pick_pixel();
        int r = $urandom_range(99);
        if (key_on && r < 30) return key_val;
        if (r < 35) return 16'h0000;
        if (r < 40) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Loads any neighbor of the request that was never written, so that the
    // store is never read at an undefined word.
    task automatic send_request(logic [9:0] cx, logic [9:0] cy, logic [11:0] px,
                                logic [11:0] py);
        longint ix, iy;
        int a;
        ix = (longint'(cx) * scale_ratio(src_w, trg_w)) >> bss_pkg::FRAC_BITS;
        iy = (longint'(cy) * scale_ratio(src_h, trg_h)) >> bss_pkg::FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
            a = store_addr(ix + (k & 1), iy + (k >> 1));
            if (!loaded[a])
                send_item(bss_pkg::OP_LOAD, pick_pixel(), 10'(a % bss_pkg::SRC_MAX_WIDTH),
                          10'(a / bss_pkg::SRC_MAX_WIDTH), 12'($urandom), 12'($urandom));
        end
        send_item(bss_pkg::OP_REQUEST, 16'($urandom), cx, cy, px, py);
    endtask

    // Waits until every result is back and the pipeline has emptied.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_px.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            bss_pkg::REG_SRC_WIDTH:  src_w   = val[8:0];
            bss_pkg::REG_SRC_HEIGHT: src_h   = val[8:0];
            bss_pkg::REG_TRG_WIDTH:  trg_w   = val[10:0];
            bss_pkg::REG_TRG_HEIGHT: trg_h   = val[10:0];
            bss_pkg::REG_KEY_ENABLE: key_on  = val[0];
            bss_pkg::REG_KEY_COLOR:  key_val = val;
            bss_pkg::REG_DEST_PITCH: pitch   = val[12:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(int sw, int sh, int tw, int th, bit ke, logic [15:0] kc, int dp);
        settle();
        write_reg(bss_pkg::REG_SRC_WIDTH, 16'(sw));
        write_reg(bss_pkg::REG_SRC_HEIGHT, 16'(sh));
        write_reg(bss_pkg::REG_TRG_WIDTH, 16'(tw));
        write_reg(bss_pkg::REG_TRG_HEIGHT, 16'(th));
        write_reg(bss_pkg::REG_KEY_ENABLE, 16'(ke));
        write_reg(bss_pkg::REG_KEY_COLOR, kc);
        write_reg(bss_pkg::REG_DEST_PITCH, 16'(dp));
    endtask

    // ---------------- tests ----------------
    task automatic test_reset_settings();
        send_request(10'd0, 10'd0, 12'd100, 12'd50);
        send_request(10'd0, 10'd0, 12'd0, 12'd0);
        send_request(10'd1, 10'd0, 12'd3, 12'd3);
    endtask

    task automatic test_directed();
        configure(5, 4, 9, 7, 1'b1, 16'hF81F, 640);
        // Loads outside the store are dropped.
        send_item(bss_pkg::OP_LOAD, 16'h1234, 10'd1023, 10'd3, 12'h000, 12'h000);
        send_item(bss_pkg::OP_LOAD, 16'h4321, 10'd2, 10'd1023, 12'h000, 12'h000);
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 5; x++)
                send_item(bss_pkg::OP_LOAD,
                          (x + y) % 3 == 0 ? 16'hF81F : (x[0] ? 16'hFFFF : 16'h0000),
                          10'(x), 10'(y), 12'h000, 12'h000);
        send_request(10'd0, 10'd0, 12'd10, 12'd10);
        send_request(10'd8, 10'd6, 12'd10, 12'd10);
        send_request(10'd4, 10'd3, 12'd10, 12'd10);
        send_request(10'd9, 10'd2, 12'd10, 12'd10);     // column past target
        send_request(10'd1023, 10'd1023, 12'd10, 12'd10);
        send_request(10'd2, 10'd2, 12'h800, 12'h800);   // negative address
        send_request(10'd2, 10'd2, 12'h7FF, 12'h7FF);   // address past the end
        configure(0, 0, 0, 0, 1'b0, 16'h0000, 0);       // zero sizes
        send_request(10'd0, 10'd0, 12'd5, 12'd5);
        send_request(10'd1023, 10'd0, 12'h7FF, 12'h800);
        configure(511, 511, 2047, 2047, 1'b0, 16'hFFFF, 8191);
        send_request(10'd1023, 10'd1023, 12'd0, 12'd0);
        send_request(10'd0, 10'd1, 12'd0, 12'd0);
        settle();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_request(10'd17, 10'd3, 12'd0, 12'd0);
    endtask

    // Counts every transaction sent, including the loads a request pulls in.
    task automatic random_phase(int n, bit wide);
        int r;
        int first;
        logic [9:0] cx, cy;
        logic [11:0] px, py;
        int tw_lim, th_lim;
        tw_lim = (trg_w == 0) ? 1 : (trg_w > 1024 ? 1024 : int'(trg_w));
        th_lim = (trg_h == 0) ? 1 : (trg_h > 1024 ? 1024 : int'(trg_h));
        first = sent_count;
        while (sent_count - first < n) begin
            r = $urandom_range(99);
            if (r < 10) begin
                send_item(bss_pkg::OP_LOAD, pick_pixel(),
                          r < 3 ? 10'($urandom)
                                : 10'($urandom_range(bss_pkg::SRC_MAX_WIDTH - 1)),
                          r < 5 ? 10'($urandom)
                                : 10'($urandom_range(bss_pkg::SRC_MAX_HEIGHT - 1)),
                          12'($urandom), 12'($urandom));
            end else begin
                cx = (r < 18) ? 10'($urandom) : 10'($urandom_range(tw_lim - 1));
                cy = (r < 18) ? 10'($urandom) : 10'($urandom_range(th_lim - 1));
                px = (wide || r > 92) ? 12'($urandom) : 12'($urandom_range(300));
                py = (wide || r > 92) ? 12'($urandom) : 12'($urandom_range(300));
                send_request(cx, cy, px, py);
            end
        end
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            configure($urandom_range(2, 16), $urandom_range(2, 16),
                      $urandom_range(1, 64), $urandom_range(1, 64),
                      p[0], $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom),
                      $urandom_range(1, 4096));
            random_phase(130, p == 5);
        end
        configure(256, 256, 1024, 1024, 1'b1, 16'h0000, 4096);
        random_phase(60, 1'b0);
        configure(256, 2, 1, 1024, 1'b1, 16'hFFFF, 1);
        random_phase(40, 1'b1);
    endtask

    task automatic test_no_idling();
        configure($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(1, 40),
                  $urandom_range(1, 40), 1'b1, 16'($urandom), $urandom_range(1, 2048));
        idling_on = 1'b0;
        random_phase(150, 1'b0);
        settle();
        idling_on = 1'b1;
    endtask

    initial begin
        src_w = 9'd2;
        src_h = 9'd2;
        trg_w = 11'd1;
        trg_h = 11'd1;
        key_on = 1'b0;
        key_val = 16'h0000;
        pitch = 13'd640;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_settings();
        test_directed();
        test_random_settings();
        test_no_idling();
        settle();
        if (err_count == 0)
            $display("tb_bilinear_sprite_scaler_color_key: done, clean");
        else
            $display("tb_bilinear_sprite_scaler_color_key: done, errors");
        $finish;
    end

endmodule
